// ===== hdl/pifd_pkg.sv =====
// Package for the pulse interval frame decoder: register indexes, reset values,
// field widths and the struct shared by the configuration block and the core.
// No dependencies.
package pifd_pkg;

   localparam int TIME_W    = 16;   // timestamp and interval width
   localparam int LEN_W     = 7;    // frame and header length registers
   localparam int MASK_W    = 64;   // width of the frame mask on the result word
   localparam int COUNT_W   = 32;   // running counters
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP_THRESHOLD = 3'd0,
      CSR_MIN_INTERVAL  = 3'd1,
      CSR_MAX_INTERVAL  = 3'd2,
      CSR_BIT_THRESHOLD = 3'd3,
      CSR_FRAME_LENGTH  = 3'd4,
      CSR_HEADER_LENGTH = 3'd5
   } csr_index_type;

   localparam logic [TIME_W-1:0] GAP_THRESHOLD_RESET = 16'd1000;
   localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET  = 16'd75;
   localparam logic [TIME_W-1:0] MAX_INTERVAL_RESET  = 16'd450;
   localparam logic [TIME_W-1:0] BIT_THRESHOLD_RESET = 16'd225;
   localparam logic [LEN_W-1:0]  FRAME_LENGTH_RESET  = 7'd64;
   localparam logic [LEN_W-1:0]  HEADER_LENGTH_RESET = 7'd8;

   // Configuration as the core sees it; lengths are already clamped.
   typedef struct packed {
      logic [TIME_W-1:0] gap_threshold;
      logic [TIME_W-1:0] min_interval;
      logic [TIME_W-1:0] max_interval;
      logic [TIME_W-1:0] bit_threshold;
      logic [LEN_W-1:0]  frame_len;
      logic [LEN_W-1:0]  header_len;
   } cfg_type;

endpackage

// ===== hdl/pifd_if.sv =====
// Channel interfaces of the pulse interval frame decoder: the timestamp word
// going in and the result word coming out. Depends on pifd_pkg.
interface pifd_req_if;
   logic                       valid;
   logic                       ready;
   logic [pifd_pkg::TIME_W-1:0] capture_time;
   logic                       lost_data;

   modport source (output valid, capture_time, lost_data, input ready);
   modport sink   (input valid, capture_time, lost_data, output ready);
endinterface

interface pifd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        frame_ready;
   logic [pifd_pkg::MASK_W-1:0]  frame_mask;
   logic [pifd_pkg::COUNT_W-1:0] frame_number;
   logic [pifd_pkg::COUNT_W-1:0] bad_frames;
   logic [pifd_pkg::COUNT_W-1:0] capture_count;
   logic [pifd_pkg::COUNT_W-1:0] overrun_count;

   modport source (output valid, frame_ready, frame_mask, frame_number, bad_frames,
                   capture_count, overrun_count, input ready);
   modport sink   (input valid, frame_ready, frame_mask, frame_number, bad_frames,
                   capture_count, overrun_count, output ready);
endinterface

// ===== hdl/pifd_csr.sv =====
// Configuration registers of the pulse interval frame decoder, with the
// clamped frame and header lengths. Depends on pifd_pkg.
module pifd_csr #(
   parameter int MAX_FRAME_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pifd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pifd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output pifd_pkg::cfg_type                cfg
);
   import pifd_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BITS);

   logic [TIME_W-1:0] gap_ff, gap_in;
   logic [TIME_W-1:0] min_ff, min_in;
   logic [TIME_W-1:0] max_ff, max_in;
   logic [TIME_W-1:0] bit_ff, bit_in;
   logic [LEN_W-1:0]  flen_ff, flen_in;
   logic [LEN_W-1:0]  hlen_ff, hlen_in;
   logic [LEN_W-1:0]  eff_len;

   always_comb begin
      gap_in  = gap_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      bit_in  = bit_ff;
      flen_in = flen_ff;
      hlen_in = hlen_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GAP_THRESHOLD: gap_in  = csr_write_data;
            CSR_MIN_INTERVAL:  min_in  = csr_write_data;
            CSR_MAX_INTERVAL:  max_in  = csr_write_data;
            CSR_BIT_THRESHOLD: bit_in  = csr_write_data;
            CSR_FRAME_LENGTH:  flen_in = csr_write_data[LEN_W-1:0];
            CSR_HEADER_LENGTH: hlen_in = csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff  <= GAP_THRESHOLD_RESET;
         min_ff  <= MIN_INTERVAL_RESET;
         max_ff  <= MAX_INTERVAL_RESET;
         bit_ff  <= BIT_THRESHOLD_RESET;
         flen_ff <= FRAME_LENGTH_RESET;
         hlen_ff <= HEADER_LENGTH_RESET;
      end else begin
         gap_ff  <= gap_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         bit_ff  <= bit_in;
         flen_ff <= flen_in;
         hlen_ff <= hlen_in;
      end
   end

   // A length of zero acts as one bit; lengths beyond the store are cut to it.
   always_comb begin
      if (flen_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (flen_ff > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = flen_ff;
      end
   end

   assign cfg.gap_threshold = gap_ff;
   assign cfg.min_interval  = min_ff;
   assign cfg.max_interval  = max_ff;
   assign cfg.bit_threshold = bit_ff;
   assign cfg.frame_len     = eff_len;
   assign cfg.header_len    = (hlen_ff > eff_len) ? eff_len : hlen_ff;

endmodule

// ===== hdl/pifd_core.sv =====
// Decoding core: input word register, the decoder state with its one-pass
// update, and the result word register. Depends on pifd_pkg and pifd_if.
module pifd_core #(
   parameter int MAX_FRAME_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  pifd_pkg::cfg_type cfg,
   pifd_req_if.sink          req_port,
   pifd_rsp_if.source        rsp_port
);
   import pifd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BITS + 2);
   localparam int IDX_W = $clog2(MAX_FRAME_BITS);
   localparam int CMP_W = LEN_W + 1;

   // Input stage.
   logic              in_valid_ff, in_valid_in;
   logic [TIME_W-1:0] in_time_ff;
   logic              in_lost_ff;
   logic              req_take;
   logic              advance;

   // Decoder state.
   logic [TIME_W-1:0]         prev_ff, prev_in;
   logic                      have_prev_ff, have_prev_in;
   logic                      inside_ff, inside_in;
   logic [MAX_FRAME_BITS-1:0] store_ff, store_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      half_ff, half_in;
   logic [COUNT_W-1:0]        good_ff, good_in;
   logic [COUNT_W-1:0]        bad_ff, bad_in;
   logic [COUNT_W-1:0]        capt_ff, capt_in;
   logic [COUNT_W-1:0]        over_ff, over_in;

   // Result stage.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_ready_ff, ready_in;
   logic [MASK_W-1:0]    out_mask_ff, mask_in;
   logic [COUNT_W-1:0]   out_good_ff, out_bad_ff, out_capt_ff, out_over_ff;

   logic [MAX_FRAME_BITS-1:0] header_mask;
   logic [TIME_W-1:0]         dt;
   logic                      frame_ok;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign req_take     = req_port.valid && req_port.ready;
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      for (int i = 0; i < MAX_FRAME_BITS; i++) begin
         header_mask[i] = CMP_W'(i) < {1'b0, cfg.header_len};
      end
   end

   assign dt = in_time_ff - prev_ff;
   assign frame_ok = ({{(CMP_W - CNT_W){1'b0}}, count_ff} == {1'b0, cfg.frame_len})
                     && ((store_ff & header_mask) == header_mask);

   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      inside_in    = inside_ff;
      store_in     = store_ff;
      count_in     = count_ff;
      half_in      = half_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      capt_in      = capt_ff;
      over_in      = over_ff;
      ready_in     = 1'b0;
      mask_in      = '0;

      if (in_lost_ff) begin
         // Overrun: drop the reference time and abort the frame.
         over_in      = over_ff + COUNT_W'(1);
         have_prev_in = 1'b0;
         if (count_ff != '0) begin
            bad_in = bad_ff + COUNT_W'(1);
         end
         inside_in = 1'b0;
         count_in  = '0;
         half_in   = 1'b0;
         store_in  = '0;
      end else begin
         capt_in = capt_ff + COUNT_W'(1);
         prev_in = in_time_ff;
         have_prev_in = 1'b1;
         if (have_prev_ff) begin
            if (dt > cfg.gap_threshold) begin
               // Frame boundary: close the running frame and start a new one.
               if (inside_ff) begin
                  if (frame_ok) begin
                     ready_in = 1'b1;
                     mask_in  = MASK_W'(store_ff);
                     good_in  = good_ff + COUNT_W'(1);
                  end else if (count_ff != '0) begin
                     bad_in = bad_ff + COUNT_W'(1);
                  end
               end
               inside_in = 1'b1;
               count_in  = '0;
               half_in   = 1'b0;
               store_in  = '0;
            end else if (inside_ff) begin
               if (dt < cfg.min_interval || dt > cfg.max_interval
                   || (dt > cfg.bit_threshold && half_ff)) begin
                  if (count_ff != '0) begin
                     bad_in = bad_ff + COUNT_W'(1);
                  end
                  inside_in = 1'b0;
                  count_in  = '0;
                  half_in   = 1'b0;
                  store_in  = '0;
               end else begin
                  if (dt > cfg.bit_threshold) begin
                     count_in = count_ff + CNT_W'(1);
                  end else if (!half_ff) begin
                     half_in = 1'b1;
                  end else begin
                     half_in = 1'b0;
                     if (count_ff < CNT_W'(MAX_FRAME_BITS)) begin
                        store_in[count_ff[IDX_W-1:0]] = 1'b1;
                     end
                     count_in = count_ff + CNT_W'(1);
                  end
                  // Too many bits for the frame: abort.
                  if ({{(CMP_W - CNT_W){1'b0}}, count_in} > {1'b0, cfg.frame_len}) begin
                     bad_in    = bad_ff + COUNT_W'(1);
                     inside_in = 1'b0;
                     count_in  = '0;
                     half_in   = 1'b0;
                     store_in  = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         inside_ff    <= 1'b0;
         store_ff     <= '0;
         count_ff     <= '0;
         half_ff      <= 1'b0;
         good_ff      <= '0;
         bad_ff       <= '0;
         capt_ff      <= '0;
         over_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            prev_ff      <= prev_in;
            have_prev_ff <= have_prev_in;
            inside_ff    <= inside_in;
            store_ff     <= store_in;
            count_ff     <= count_in;
            half_ff      <= half_in;
            good_ff      <= good_in;
            bad_ff       <= bad_in;
            capt_ff      <= capt_in;
            over_ff      <= over_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_time_ff <= req_port.capture_time;
         in_lost_ff <= req_port.lost_data;
      end
      if (advance) begin
         out_ready_ff <= ready_in;
         out_mask_ff  <= mask_in;
         out_good_ff  <= good_in;
         out_bad_ff   <= bad_in;
         out_capt_ff  <= capt_in;
         out_over_ff  <= over_in;
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.frame_ready   = out_ready_ff;
   assign rsp_port.frame_mask    = out_mask_ff;
   assign rsp_port.frame_number  = out_good_ff;
   assign rsp_port.bad_frames    = out_bad_ff;
   assign rsp_port.capture_count = out_capt_ff;
   assign rsp_port.overrun_count = out_over_ff;

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_time_ff) && $stable(in_lost_ff))
      else $error("input word changed while stalled");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> count_ff == '0 && !half_ff && store_ff == '0)
      else $error("bit state left over outside a frame");

   // The frame length may shrink while a frame is open, so the count is only
   // bounded by the size of the bit store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_BITS))
      else $error("bit count beyond the bit store");

   a_good_step: assert property (@(posedge clock) disable iff (reset)
      advance && ready_in |=> out_ready_ff && good_ff == $past(good_ff) + COUNT_W'(1))
      else $error("valid frame not counted");

   a_mask_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready_ff |-> out_mask_ff == '0)
      else $error("mask shown without a valid frame");
`endif

endmodule

// ===== hdl/pulse_interval_frame_decoder.sv =====
// Top level of the pulse interval frame decoder: configuration registers and
// decoding core. Depends on pifd_pkg, pifd_if, pifd_csr and pifd_core.
//
// The decoder takes one word per clock cycle on req_port while rsp_port is not
// stalled: a 16-bit falling-edge timestamp in microseconds, or an overrun
// marker. It returns exactly one word per input word on rsp_port: the input
// word is registered, the whole decode (wrapping interval, gap, plausibility
// and bit-threshold compares, bit insertion and counter updates) runs
// combinationally against the decoder state, and the result lands in an output
// register, so the sustained rate is one word per cycle while rsp_port.ready is
// high; while a finished result waits for rsp_port.ready the input register can
// still take one word, after which req_port.ready stays low until the result is
// taken. A result word carries frame_ready and the frame mask (zero unless a
// valid frame closed on this word) plus the running valid-frame, bad-frame,
// capture and overrun counts. A frame closes when a gap longer than the gap
// threshold is seen; it is valid when it holds exactly frame_length bits and
// its first header_length bits are all one. The user must write configuration
// registers through the csr_ port only while the block is idle; the block
// itself does not enforce this. Unknown indexes are ignored. MAX_FRAME_BITS
// sizes the bit store (8 to 64); frame_mask is always 64 bits, zero-extended.
module pulse_interval_frame_decoder #(
   parameter int MAX_FRAME_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [pifd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pifd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   pifd_req_if.sink                         req_port,
   pifd_rsp_if.source                       rsp_port
);
   import pifd_pkg::*;

   // Clamped configuration shared by the decode logic.
   cfg_type cfg;

   pifd_csr #(
      .MAX_FRAME_BITS (MAX_FRAME_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pifd_core #(
      .MAX_FRAME_BITS (MAX_FRAME_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

endmodule

// ===== tb/pulse_interval_frame_decoder_test.sv =====
// Self-checking testbench for the pulse interval frame decoder: drives timestamp
// words, writes the csr_ registers between phases and checks every result word.
// Depends on pifd_pkg, pifd_if and the pulse_interval_frame_decoder RTL.
`timescale 1ns / 100ps

// One result word as the decoder should return it.
typedef struct packed {
   logic                         frame_ready;
   logic [pifd_pkg::MASK_W-1:0]  frame_mask;
   logic [pifd_pkg::COUNT_W-1:0] frame_number;
   logic [pifd_pkg::COUNT_W-1:0] bad_frames;
   logic [pifd_pkg::COUNT_W-1:0] capture_count;
   logic [pifd_pkg::COUNT_W-1:0] overrun_count;
} result_word_type;

// Mirrors the decoder state, works out the result word for every accepted
// timestamp word and compares the decoder's answers in order.
class frame_decode_tracker;
   pifd_pkg::cfg_type            regs;
   logic [pifd_pkg::TIME_W-1:0]  previous_time;
   logic                         have_previous;
   logic                         inside_frame;
   logic                         half_pending;
   logic [pifd_pkg::MASK_W-1:0]  bit_store;
   logic [pifd_pkg::LEN_W-1:0]   bit_count;
   logic [pifd_pkg::COUNT_W-1:0] good_frames;
   logic [pifd_pkg::COUNT_W-1:0] bad_frames;
   logic [pifd_pkg::COUNT_W-1:0] captures;
   logic [pifd_pkg::COUNT_W-1:0] overruns;
   result_word_type              pending[$];
   int                           mismatches;

   function new();
      regs.gap_threshold = pifd_pkg::GAP_THRESHOLD_RESET;
      regs.min_interval  = pifd_pkg::MIN_INTERVAL_RESET;
      regs.max_interval  = pifd_pkg::MAX_INTERVAL_RESET;
      regs.bit_threshold = pifd_pkg::BIT_THRESHOLD_RESET;
      regs.frame_len     = pifd_pkg::FRAME_LENGTH_RESET;
      regs.header_len    = pifd_pkg::HEADER_LENGTH_RESET;
      previous_time = '0;
      have_previous = 1'b0;
      inside_frame  = 1'b0;
      good_frames   = '0;
      bad_frames    = '0;
      captures      = '0;
      overruns      = '0;
      mismatches    = 0;
      clear_frame();
   endfunction

   function void write_register(logic [pifd_pkg::CSR_IDX_W-1:0] index,
                                logic [pifd_pkg::CSR_DATA_W-1:0] value);
      case (index)
         pifd_pkg::CSR_GAP_THRESHOLD: regs.gap_threshold = value;
         pifd_pkg::CSR_MIN_INTERVAL:  regs.min_interval  = value;
         pifd_pkg::CSR_MAX_INTERVAL:  regs.max_interval  = value;
         pifd_pkg::CSR_BIT_THRESHOLD: regs.bit_threshold = value;
         pifd_pkg::CSR_FRAME_LENGTH:  regs.frame_len     = value[pifd_pkg::LEN_W-1:0];
         pifd_pkg::CSR_HEADER_LENGTH: regs.header_len    = value[pifd_pkg::LEN_W-1:0];
         default: ;
      endcase
   endfunction

   // A length of zero counts as one bit and anything past the store counts as full.
   function logic [pifd_pkg::LEN_W-1:0] effective_length();
      if (regs.frame_len == 0) return pifd_pkg::LEN_W'(1);
      if (regs.frame_len > pifd_pkg::MASK_W) return pifd_pkg::LEN_W'(pifd_pkg::MASK_W);
      return regs.frame_len;
   endfunction

   function logic [pifd_pkg::LEN_W-1:0] effective_header();
      logic [pifd_pkg::LEN_W-1:0] len;
      len = effective_length();
      return (regs.header_len > len) ? len : regs.header_len;
   endfunction

   function logic [pifd_pkg::MASK_W-1:0] low_mask(logic [pifd_pkg::LEN_W-1:0] n);
      if (n >= pifd_pkg::MASK_W) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function void clear_frame();
      bit_count    = '0;
      half_pending = 1'b0;
      bit_store    = '0;
   endfunction

   function void abort_frame();
      if (bit_count != 0) bad_frames++;
      inside_frame = 1'b0;
      clear_frame();
   endfunction

   function void push_bit(logic value);
      if (bit_count < pifd_pkg::MASK_W && value) bit_store[bit_count[5:0]] = 1'b1;
      bit_count++;
   endfunction

   function logic close_frame(output logic [pifd_pkg::MASK_W-1:0] mask);
      logic [pifd_pkg::MASK_W-1:0] header_mask;
      logic                        good;
      mask        = '0;
      header_mask = low_mask(effective_header());
      good = (bit_count == effective_length()) && ((bit_store & header_mask) == header_mask);
      if (good) begin
         mask = bit_store & low_mask(effective_length());
         good_frames++;
      end else if (bit_count != 0) begin
         bad_frames++;
      end
      clear_frame();
      return good;
   endfunction

   function void note_word(logic [pifd_pkg::TIME_W-1:0] capture_time, logic lost_data);
      result_word_type             expected;
      logic [pifd_pkg::TIME_W-1:0] interval;
      expected = '0;
      if (lost_data) begin
         overruns++;
         have_previous = 1'b0;
         abort_frame();
      end else begin
         captures++;
         if (!have_previous) begin
            previous_time = capture_time;
            have_previous = 1'b1;
         end else begin
            interval      = capture_time - previous_time;
            previous_time = capture_time;
            if (interval > regs.gap_threshold) begin
               if (inside_frame) expected.frame_ready = close_frame(expected.frame_mask);
               inside_frame = 1'b1;
               clear_frame();
            end else if (inside_frame) begin
               if (interval < regs.min_interval || interval > regs.max_interval) begin
                  abort_frame();
               end else if (interval > regs.bit_threshold) begin
                  if (half_pending) abort_frame();
                  else push_bit(1'b0);
               end else if (!half_pending) begin
                  half_pending = 1'b1;
               end else begin
                  half_pending = 1'b0;
                  push_bit(1'b1);
               end
               if (bit_count > effective_length()) abort_frame();
            end
         end
      end
      expected.frame_number  = good_frames;
      expected.bad_frames    = bad_frames;
      expected.capture_count = captures;
      expected.overrun_count = overruns;
      pending.push_back(expected);
   endfunction

   function bit field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (want === got) return 1'b0;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      return 1'b1;
   endfunction

   function void check_result(result_word_type actual);
      result_word_type expected;
      if (pending.size() == 0) begin
         $display("%0t: result word expected none, actual capture_count %0d",
                  $time, actual.capture_count);
         mismatches++;
         return;
      end
      expected = pending.pop_front();
      mismatches += field_differs("frame_ready", 64'(expected.frame_ready),
                                  64'(actual.frame_ready));
      mismatches += field_differs("frame_mask", expected.frame_mask, actual.frame_mask);
      mismatches += field_differs("frame_number", 64'(expected.frame_number),
                                  64'(actual.frame_number));
      mismatches += field_differs("bad_frames", 64'(expected.bad_frames),
                                  64'(actual.bad_frames));
      mismatches += field_differs("capture_count", 64'(expected.capture_count),
                                  64'(actual.capture_count));
      mismatches += field_differs("overrun_count", 64'(expected.overrun_count),
                                  64'(actual.overrun_count));
   endfunction
endclass

module pulse_interval_frame_decoder_test;
   import pifd_pkg::*;

   localparam int STALL_LIMIT   = 1000;  // cycles without any accepted word
   localparam int SETTLE_CYCLES = 4;     // margin past the input and output registers
   localparam int IDLE_PERCENT  = 36;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   // Ways in which a random frame gets broken part way through.
   typedef enum {FAULT_SHORT, FAULT_LONG, FAULT_SPLIT_BIT, FAULT_OVERRUN, FAULT_STRAY}
      fault_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pifd_req_if req_bus ();
   pifd_rsp_if rsp_bus ();

   frame_decode_tracker tracker = new();

   // Timer value of the last timestamp word sent, so that intervals can be chosen.
   logic [TIME_W-1:0] now_us = '0;
   int words_sent   = 0;
   int stall_cycles = 0;
   // While set, neither side idles.
   bit steady = 1'b0;

   pulse_interval_frame_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The result side stalls at random, changing only at the falling edge.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Every result word accepted at a rising edge is checked against the oldest
   // expectation. The stall counter feeds the watchdog below.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_result(result_word_type'{rsp_bus.frame_ready, rsp_bus.frame_mask,
                                                   rsp_bus.frame_number, rsp_bus.bad_frames,
                                                   rsp_bus.capture_count,
                                                   rsp_bus.overrun_count});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // A decoder that stops moving words ends the run.
   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("pulse_interval_frame_decoder regression: fail");
      $finish;
   end

   // Offers one word, entered and left at a falling edge. Random idle cycles
   // come first; valid stays high until the decoder takes the word.
   task automatic send_word(logic [TIME_W-1:0] capture_time, logic lost_data);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.capture_time <= capture_time;
      req_bus.lost_data    <= lost_data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_word(capture_time, lost_data);
      if (!lost_data) now_us = capture_time;
      words_sent++;
      @(negedge clock);
   endtask

   task automatic emit_interval(int interval);
      send_word(now_us + 16'(interval), 1'b0);
   endtask

   // A stray timestamp anywhere on the timer, or now and then an overrun.
   task automatic random_noise();
      if ($urandom_range(3) == 0) send_word(16'($urandom), 1'b1);
      else send_word(16'($urandom), 1'b0);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      tracker.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic set_config(int gap_us, int min_us, int max_us, int split_us,
                             int frame_bits, int header_bits);
      csr_write(CSR_GAP_THRESHOLD, CSR_DATA_W'(gap_us));
      csr_write(CSR_MIN_INTERVAL, CSR_DATA_W'(min_us));
      csr_write(CSR_MAX_INTERVAL, CSR_DATA_W'(max_us));
      csr_write(CSR_BIT_THRESHOLD, CSR_DATA_W'(split_us));
      csr_write(CSR_FRAME_LENGTH, CSR_DATA_W'(frame_bits));
      csr_write(CSR_HEADER_LENGTH, CSR_DATA_W'(header_bits));
      csr_write_enable <= 1'b0;
   endtask

   // Holds the sender back until every expected result word has come back.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sends about the given number of words, mostly whole frames with random
   // bits under the current register settings. A frame opens with a gap and is
   // closed by the gap of the next one. Some frames carry one bit too many or
   // too few, some a broken header, some a fault part way through, and noise
   // words fall between frames.
   task automatic run_random(int target);
      int             first, gap_us, min_us, max_us;
      int             short_lo, short_hi, long_lo, long_hi;
      int             frame_bits, header_bits, fault_at, i;
      bit             has_short, has_long, clean_header, broken, one;
      fault_kind_type fault;
      first  = words_sent;
      gap_us = tracker.regs.gap_threshold;
      min_us = tracker.regs.min_interval;
      max_us = tracker.regs.max_interval;
      // In-frame intervals must stay at or below the gap threshold.
      short_lo = min_us;
      short_hi = tracker.regs.bit_threshold;
      if (max_us < short_hi) short_hi = max_us;
      if (gap_us < short_hi) short_hi = gap_us;
      long_lo = int'(tracker.regs.bit_threshold) + 1;
      if (min_us > long_lo) long_lo = min_us;
      long_hi = (gap_us < max_us) ? gap_us : max_us;
      has_short = short_lo <= short_hi;
      has_long  = long_lo <= long_hi;
      while (words_sent - first < target) begin
         if (gap_us >= 65535 || !(has_short || has_long)) begin
            // No gap or no bit can ever be seen here, so only noise is left to send.
            random_noise();
         end else begin
            if ($urandom_range(99) < 15) random_noise();
            emit_interval($urandom_range(65535, gap_us + 1));
            frame_bits  = tracker.effective_length();
            header_bits = tracker.effective_header();
            if ($urandom_range(9) == 0) begin
               frame_bits = ($urandom_range(1) && frame_bits > 1) ? frame_bits - 1
                                                                  : frame_bits + 1;
            end
            clean_header = $urandom_range(99) < 85;
            broken       = $urandom_range(99) < 20;
            fault_at     = $urandom_range(frame_bits);
            fault        = fault_kind_type'($urandom_range(4));
            for (i = 0; i <= frame_bits; i++) begin
               if (broken && i == fault_at) begin
                  case (fault)
                     FAULT_SHORT: begin
                        if (min_us > 0) emit_interval($urandom_range(min_us - 1, 0));
                        else random_noise();
                     end
                     FAULT_LONG: begin
                        if (max_us < gap_us) emit_interval($urandom_range(gap_us, max_us + 1));
                        else random_noise();
                     end
                     FAULT_SPLIT_BIT: begin
                        // A half slot followed by a long interval.
                        if (has_short && has_long) begin
                           emit_interval($urandom_range(short_hi, short_lo));
                           emit_interval($urandom_range(long_hi, long_lo));
                        end else begin
                           random_noise();
                        end
                     end
                     FAULT_OVERRUN: send_word(16'($urandom), 1'b1);
                     FAULT_STRAY:   random_noise();
                  endcase
               end
               if (i < frame_bits) begin
                  one = (i < header_bits && clean_header) ? 1'b1 : 1'($urandom_range(1));
                  if (!has_short) one = 1'b0;
                  if (!has_long) one = 1'b1;
                  if (one) begin
                     emit_interval($urandom_range(short_hi, short_lo));
                     emit_interval($urandom_range(short_hi, short_lo));
                  end else begin
                     emit_interval($urandom_range(long_hi, long_lo));
                  end
               end
            end
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_GAP_THRESHOLD;
      csr_write_data       <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.capture_time <= '0;
      req_bus.lost_data    <= 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed words with four-bit frames and two header bits.
      set_config(1000, 75, 450, 225, 4, 2);
      // An overrun with the timer field at its top is counted, its time ignored.
      send_word(16'hFFFF, 1'b1);
      // The first timestamp is only stored.
      send_word(16'd0, 1'b0);
      // Outside a frame a short interval changes nothing.
      send_word(16'd500, 1'b0);
      // A gap opens a frame, then the timer wraps: two 1 bits and two 0 bits.
      send_word(16'd65535, 1'b0);
      send_word(16'd99, 1'b0);
      send_word(16'd199, 1'b0);
      send_word(16'd299, 1'b0);
      send_word(16'd399, 1'b0);
      send_word(16'd699, 1'b0);
      send_word(16'd999, 1'b0);
      // This gap closes a good frame with mask 0011 and opens the next one.
      send_word(16'd3000, 1'b0);
      // A 0 bit, then a half slot cut short by a long interval: the frame aborts.
      send_word(16'd3300, 1'b0);
      send_word(16'd3400, 1'b0);
      send_word(16'd3700, 1'b0);
      // A new frame whose second interval is too long to be a bit.
      send_word(16'd5000, 1'b0);
      send_word(16'd5300, 1'b0);
      send_word(16'd5800, 1'b0);
      // Four 0 bits: the length fits but the header does not.
      send_word(16'd7000, 1'b0);
      send_word(16'd7300, 1'b0);
      send_word(16'd7600, 1'b0);
      send_word(16'd7900, 1'b0);
      send_word(16'd8200, 1'b0);
      send_word(16'd10000, 1'b0);
      // An overrun in the middle of a frame drops both the frame and the timestamp.
      send_word(16'd10300, 1'b0);
      send_word(16'd0, 1'b1);
      send_word(16'd12000, 1'b0);
      quiesce();

      // Eight-bit frames with a short gap.
      set_config(500, 20, 300, 150, 8, 3);
      run_random(140);
      quiesce();

      // Every threshold at zero: only repeated timestamps are half slots, any
      // other interval is a gap, and a frame is a single 1 bit with no header.
      set_config(0, 0, 65535, 0, 1, 0);
      run_random(70);
      quiesce();

      // A frame length of zero acts as one bit and the header is cut to it.
      set_config(2000, 10, 1500, 700, 0, 64);
      run_random(70);
      quiesce();

      // Every register at its top: no gap can ever be seen.
      set_config(65535, 65535, 65535, 65535, 127, 127);
      run_random(30);
      quiesce();

      // Full 64-bit frames whose header covers the whole frame, with no idling.
      steady = 1'b1;
      set_config(1000, 75, 450, 225, 127, 127);
      run_random(220);
      quiesce();
      steady = 1'b0;

      // A write to an unused index must leave the registers alone.
      csr_write(CSR_SPARE_INDEX, 16'hFFFF);
      set_config(300, 100, 250, 180, 12, 4);
      run_random(140);
      quiesce();

      if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
         $display("pulse_interval_frame_decoder regression: pass");
      end else begin
         $display("pulse_interval_frame_decoder regression: fail");
      end
      $finish;
   end
endmodule
